/* hw/rtl/ohlcb_pkg.sv */
`default_nettype none

package ohlcb_pkg;

  // Field widths on the channels
  localparam int CMD_W   = 1;
  localparam int PRICE_W = 24;
  localparam int VOL_W   = 24;
  localparam int OI_W    = 32;
  localparam int TOTAL_W = 32;

  // Internal widths
  localparam int PRICE_BITS = 24;
  localparam int TOTAL_BITS = 32;
  localparam int SUM_BITS   = 56;
  localparam int PROD_BITS  = PRICE_BITS + VOL_W;

  // Radix-4 multiplier: two multiplier bits per cycle
  localparam int MUL_DIGITS   = (PRICE_BITS + 1) / 2;
  localparam int MUL_SR_BITS  = 2 * MUL_DIGITS;
  localparam int MUL_CNT_BITS = $clog2(MUL_DIGITS + 1);

  // Restoring divider: one quotient bit per cycle
  localparam int HI_BITS      = SUM_BITS - PRICE_BITS;
  localparam int CMP_BITS     = (HI_BITS > TOTAL_BITS) ? HI_BITS : TOTAL_BITS;
  localparam int DIV_CNT_BITS = $clog2(PRICE_BITS + 1);

  // Saturating adder widths
  localparam int VADD_BITS = ((TOTAL_BITS > VOL_W) ? TOTAL_BITS : VOL_W) + 1;

  typedef logic [PRICE_W-1:0]      fprice_t;
  typedef logic [VOL_W-1:0]        vol_t;
  typedef logic [OI_W-1:0]         oi_t;
  typedef logic [TOTAL_W-1:0]      ftotal_t;
  typedef logic [PRICE_BITS-1:0]   price_t;
  typedef logic [TOTAL_BITS-1:0]   total_t;
  typedef logic [TOTAL_BITS:0]     total_ext_t;
  typedef logic [SUM_BITS-1:0]     sum_t;
  typedef logic [SUM_BITS:0]       sum_ext_t;
  typedef logic [PROD_BITS-1:0]    prod_t;
  typedef logic [MUL_SR_BITS-1:0]  mul_sr_t;
  typedef logic [MUL_CNT_BITS-1:0] mul_cnt_t;
  typedef logic [HI_BITS-1:0]      hi_t;
  typedef logic [CMP_BITS-1:0]     cmp_t;
  typedef logic [DIV_CNT_BITS-1:0] div_cnt_t;
  typedef logic [VADD_BITS-1:0]    vadd_t;

  localparam total_t TOTAL_MAX = '1;
  localparam sum_t   SUM_MAX   = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK  = 1'b0,
    CMD_CLEAR = 1'b1
  } cmd_t;

  // Status of an arithmetic unit back to the sequencer
  typedef struct packed {
    logic busy;
  } unit_stat_t;

endpackage

`default_nettype wire

/* hw/rtl/ohlcb_in_if.sv */
`default_nettype none

interface ohlcb_in_if;
  logic                valid;
  logic                ready;
  ohlcb_pkg::cmd_t     command;
  ohlcb_pkg::fprice_t  price;
  ohlcb_pkg::vol_t     trade_volume;
  ohlcb_pkg::oi_t      open_interest_in;

  modport source (output valid, command, price, trade_volume, open_interest_in,
                  input ready);
  modport sink   (input valid, command, price, trade_volume, open_interest_in,
                  output ready);
endinterface

`default_nettype wire

/* hw/rtl/ohlcb_out_if.sv */
`default_nettype none

interface ohlcb_out_if;
  logic                valid;
  logic                ready;
  ohlcb_pkg::fprice_t  open_price;
  ohlcb_pkg::fprice_t  high_price;
  ohlcb_pkg::fprice_t  low_price;
  ohlcb_pkg::fprice_t  close_price;
  ohlcb_pkg::ftotal_t  total_volume;
  ohlcb_pkg::ftotal_t  ticks_seen;
  ohlcb_pkg::fprice_t  volume_weighted_average;
  ohlcb_pkg::fprice_t  time_weighted_average;
  ohlcb_pkg::oi_t      open_interest_out;

  modport source (output valid, open_price, high_price, low_price, close_price,
                  total_volume, ticks_seen, volume_weighted_average,
                  time_weighted_average, open_interest_out,
                  input ready);
  modport sink   (input valid, open_price, high_price, low_price, close_price,
                  total_volume, ticks_seen, volume_weighted_average,
                  time_weighted_average, open_interest_out,
                  output ready);
endinterface

`default_nettype wire

/* hw/rtl/ohlc_bar_vwap_twap_unit.sv */
`default_nettype none

// OHLC bar builder with VWAP and TWAP.
// in_ch: one tick transaction per valid/ready handshake. command selects a
//   new tick or a clear of the bar; price, trade_volume, open_interest_in
//   are ignored on a clear.
// out_ch: exactly one bar snapshot transaction per accepted input, in order.
// One tick is processed at a time. After acceptance the product
//   price*volume runs through a radix-4 shift-add multiplier, the bar is
//   updated, the dividers are started, then TWAP and VWAP run in two
//   parallel restoring dividers, one quotient bit per cycle, and the
//   snapshot is loaded into the output register. A clear skips the
//   arithmetic and goes straight to the output stage.
//   in_ch.ready is high only while the sequencer is idle, so a new tick is
//   not taken until the previous result is loaded into the output register.
// The result sits in an output register; a stalled receiver holds it, and
//   the next tick is taken and computed meanwhile, waiting only at the end
//   for the register to free up.
// Reset (synchronous, active low) empties the bar and drops any pending
// result.
module ohlc_bar_vwap_twap_unit (
  input wire logic   clk,
  input wire logic   rst_n,
  ohlcb_in_if.sink   in_ch,
  ohlcb_out_if.source out_ch
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_UPD,
    S_DIVG,
    S_DIVW,
    S_OUT
  } state_t;

  state_t state_r;

  // Bar state
  logic                started_r;
  ohlcb_pkg::price_t   open_r;
  ohlcb_pkg::price_t   high_r;
  ohlcb_pkg::price_t   low_r;
  ohlcb_pkg::price_t   close_r;
  ohlcb_pkg::total_t   vol_sum_r;
  ohlcb_pkg::total_t   tick_cnt_r;
  ohlcb_pkg::sum_t     pv_sum_r;
  ohlcb_pkg::sum_t     p_sum_r;
  ohlcb_pkg::oi_t      oi_r;

  // Latched tick and clear marker
  ohlcb_pkg::price_t   price_l_r;
  ohlcb_pkg::vol_t     vol_l_r;
  logic                clear_r;

  // Output register
  logic                out_valid_r;
  ohlcb_pkg::fprice_t  o_open_r;
  ohlcb_pkg::fprice_t  o_high_r;
  ohlcb_pkg::fprice_t  o_low_r;
  ohlcb_pkg::fprice_t  o_close_r;
  ohlcb_pkg::ftotal_t  o_vol_r;
  ohlcb_pkg::ftotal_t  o_ticks_r;
  ohlcb_pkg::fprice_t  o_vwap_r;
  ohlcb_pkg::fprice_t  o_twap_r;
  ohlcb_pkg::oi_t      o_oi_r;

  logic                in_acc;
  logic                is_clear;
  logic                out_load;
  logic                mul_start;
  logic                div_start;
  ohlcb_pkg::price_t   price_m;
  ohlcb_pkg::prod_t    prod;
  ohlcb_pkg::unit_stat_t mul_stat;
  ohlcb_pkg::unit_stat_t tdiv_stat;
  ohlcb_pkg::unit_stat_t vdiv_stat;
  ohlcb_pkg::price_t   twap_q;
  ohlcb_pkg::price_t   vwap_q;

  // Update-step values
  ohlcb_pkg::sum_ext_t   pv_add;
  ohlcb_pkg::sum_ext_t   p_add;
  ohlcb_pkg::vadd_t      v_add;
  ohlcb_pkg::total_ext_t t_add;
  ohlcb_pkg::sum_t       pv_sum_nxt;
  ohlcb_pkg::sum_t       p_sum_nxt;
  ohlcb_pkg::total_t     vol_sum_nxt;
  ohlcb_pkg::total_t     tick_cnt_nxt;
  ohlcb_pkg::price_t     high_nxt;
  ohlcb_pkg::price_t     low_nxt;
  ohlcb_pkg::price_t     vwap_sel;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign is_clear    = (in_ch.command == ohlcb_pkg::CMD_CLEAR);
  assign price_m     = ohlcb_pkg::price_t'(in_ch.price);
  assign mul_start   = in_acc && !is_clear;
  assign div_start   = (state_r == S_DIVG);
  assign out_load    = (state_r == S_OUT) && (!out_valid_r || out_ch.ready);

  ohlcb_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .mcand_a (price_m),
    .mcand_b (in_ch.trade_volume),
    .stat    (mul_stat),
    .prod    (prod)
  );

  ohlcb_div u_twap_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (p_sum_r),
    .den   (tick_cnt_r),
    .stat  (tdiv_stat),
    .quo   (twap_q)
  );

  ohlcb_div u_vwap_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (pv_sum_r),
    .den   (vol_sum_r),
    .stat  (vdiv_stat),
    .quo   (vwap_q)
  );

  // First tick of a bar adds to zero, so one saturating path covers both cases
  always_comb begin
    pv_add = ohlcb_pkg::sum_ext_t'(started_r ? pv_sum_r : '0)
           + ohlcb_pkg::sum_ext_t'(prod);
    p_add  = ohlcb_pkg::sum_ext_t'(started_r ? p_sum_r : '0)
           + ohlcb_pkg::sum_ext_t'(price_l_r);
    v_add  = ohlcb_pkg::vadd_t'(started_r ? vol_sum_r : '0)
           + ohlcb_pkg::vadd_t'(vol_l_r);
    t_add  = ohlcb_pkg::total_ext_t'(started_r ? tick_cnt_r : '0)
           + ohlcb_pkg::total_ext_t'(1);

    pv_sum_nxt   = pv_add[ohlcb_pkg::SUM_BITS] ? ohlcb_pkg::SUM_MAX
                                               : pv_add[ohlcb_pkg::SUM_BITS-1:0];
    p_sum_nxt    = p_add[ohlcb_pkg::SUM_BITS] ? ohlcb_pkg::SUM_MAX
                                              : p_add[ohlcb_pkg::SUM_BITS-1:0];
    vol_sum_nxt  = (v_add > ohlcb_pkg::vadd_t'(ohlcb_pkg::TOTAL_MAX))
                   ? ohlcb_pkg::TOTAL_MAX : ohlcb_pkg::total_t'(v_add);
    tick_cnt_nxt = t_add[ohlcb_pkg::TOTAL_BITS] ? ohlcb_pkg::TOTAL_MAX
                                                : t_add[ohlcb_pkg::TOTAL_BITS-1:0];

    high_nxt = (!started_r || price_l_r > high_r) ? price_l_r : high_r;
    low_nxt  = (!started_r || price_l_r < low_r)  ? price_l_r : low_r;

    // VWAP falls back to TWAP on zero volume
    vwap_sel = (vol_sum_r == '0) ? twap_q : vwap_q;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      started_r   <= 1'b0;
      open_r      <= '0;
      high_r      <= '0;
      low_r       <= '0;
      close_r     <= '0;
      vol_sum_r   <= '0;
      tick_cnt_r  <= '0;
      pv_sum_r    <= '0;
      p_sum_r     <= '0;
      oi_r        <= '0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (is_clear) begin
              started_r  <= 1'b0;
              open_r     <= '0;
              high_r     <= '0;
              low_r      <= '0;
              close_r    <= '0;
              vol_sum_r  <= '0;
              tick_cnt_r <= '0;
              pv_sum_r   <= '0;
              p_sum_r    <= '0;
              oi_r       <= '0;
              state_r    <= S_OUT;
            end else begin
              oi_r    <= in_ch.open_interest_in;
              state_r <= S_MUL;
            end
          end
        end
        S_MUL: begin
          if (!mul_stat.busy) begin
            state_r <= S_UPD;
          end
        end
        S_UPD: begin
          if (!started_r) begin
            open_r <= price_l_r;
          end
          started_r  <= 1'b1;
          high_r     <= high_nxt;
          low_r      <= low_nxt;
          close_r    <= price_l_r;
          vol_sum_r  <= vol_sum_nxt;
          tick_cnt_r <= tick_cnt_nxt;
          pv_sum_r   <= pv_sum_nxt;
          p_sum_r    <= p_sum_nxt;
          state_r    <= S_DIVG;
        end
        S_DIVG: begin
          state_r <= S_DIVW;
        end
        S_DIVW: begin
          if (!tdiv_stat.busy && !vdiv_stat.busy) begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Payload: latched tick and the output register
  always_ff @(posedge clk) begin
    if (in_acc) begin
      price_l_r <= price_m;
      vol_l_r   <= in_ch.trade_volume;
      clear_r   <= is_clear;
    end
    if (out_load) begin
      if (clear_r) begin
        o_open_r  <= '0;
        o_high_r  <= '0;
        o_low_r   <= '0;
        o_close_r <= '0;
        o_vol_r   <= '0;
        o_ticks_r <= '0;
        o_vwap_r  <= '0;
        o_twap_r  <= '0;
        o_oi_r    <= '0;
      end else begin
        o_open_r  <= ohlcb_pkg::fprice_t'(open_r);
        o_high_r  <= ohlcb_pkg::fprice_t'(high_r);
        o_low_r   <= ohlcb_pkg::fprice_t'(low_r);
        o_close_r <= ohlcb_pkg::fprice_t'(close_r);
        o_vol_r   <= ohlcb_pkg::ftotal_t'(vol_sum_r);
        o_ticks_r <= ohlcb_pkg::ftotal_t'(tick_cnt_r);
        o_vwap_r  <= ohlcb_pkg::fprice_t'(vwap_sel);
        o_twap_r  <= ohlcb_pkg::fprice_t'(twap_q);
        o_oi_r    <= oi_r;
      end
    end
  end

  assign out_ch.valid                   = out_valid_r;
  assign out_ch.open_price              = o_open_r;
  assign out_ch.high_price              = o_high_r;
  assign out_ch.low_price               = o_low_r;
  assign out_ch.close_price             = o_close_r;
  assign out_ch.total_volume            = o_vol_r;
  assign out_ch.ticks_seen              = o_ticks_r;
  assign out_ch.volume_weighted_average = o_vwap_r;
  assign out_ch.time_weighted_average   = o_twap_r;
  assign out_ch.open_interest_out       = o_oi_r;

`ifndef SYNTH
  // Arithmetic units are quiet whenever a new transaction can be taken
  a_idle_units: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !mul_stat.busy && !tdiv_stat.busy && !vdiv_stat.busy)
    else $error("arithmetic unit busy while sequencer idle");

  // A clear skips the arithmetic and goes straight to the output stage
  a_clear_path: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && is_clear |=> state_r == S_OUT && !mul_stat.busy)
    else $error("clear transaction did not go to output stage");

  // A delivered bar never has its low above its high
  a_low_high: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.low_price <= out_ch.high_price)
    else $error("bar low above bar high");
`endif

endmodule

`default_nettype wire

/* hw/rtl/ohlcb_mul.sv */
`default_nettype none

// Radix-4 shift-add multiplier, multiplier digits taken MSB first.
module ohlcb_mul (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire ohlcb_pkg::price_t     mcand_a,
  input  wire ohlcb_pkg::vol_t       mcand_b,
  output ohlcb_pkg::unit_stat_t      stat,
  output ohlcb_pkg::prod_t           prod
);

  ohlcb_pkg::mul_sr_t  a_sr_r;
  ohlcb_pkg::vol_t     b_r;
  ohlcb_pkg::prod_t    acc_r;
  ohlcb_pkg::prod_t    acc_nxt;
  ohlcb_pkg::prod_t    pp;
  ohlcb_pkg::mul_cnt_t cnt_r;
  logic                busy_r;
  logic [1:0]          digit;

  always_comb begin
    digit   = a_sr_r[ohlcb_pkg::MUL_SR_BITS-1 -: 2];
    pp      = (digit[0] ? ohlcb_pkg::prod_t'(b_r) : '0)
            + (digit[1] ? (ohlcb_pkg::prod_t'(b_r) << 1) : '0);
    acc_nxt = (acc_r << 2) + pp;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= ohlcb_pkg::mul_cnt_t'(ohlcb_pkg::MUL_DIGITS);
    end else if (busy_r) begin
      cnt_r <= cnt_r - ohlcb_pkg::mul_cnt_t'(1);
      if (cnt_r == ohlcb_pkg::mul_cnt_t'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_sr_r <= ohlcb_pkg::mul_sr_t'(mcand_a);
      b_r    <= mcand_b;
      acc_r  <= '0;
    end else if (busy_r) begin
      a_sr_r <= a_sr_r << 2;
      acc_r  <= acc_nxt;
    end
  end

  assign stat.busy   = busy_r;
  assign prod        = acc_r;

endmodule

`default_nettype wire

/* hw/rtl/ohlcb_div.sv */
`default_nettype none

// Restoring divider with clamped quotient. An over-range quotient or a zero
// divisor is settled at start; otherwise one quotient bit per cycle.
module ohlcb_div (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire ohlcb_pkg::sum_t       num,
  input  wire ohlcb_pkg::total_t     den,
  output ohlcb_pkg::unit_stat_t      stat,
  output ohlcb_pkg::price_t          quo
);

  ohlcb_pkg::hi_t        hi;
  logic                  ovf;
  ohlcb_pkg::total_t     den_r;
  ohlcb_pkg::total_t     rem_r;
  ohlcb_pkg::price_t     lo_sr_r;
  ohlcb_pkg::price_t     q_r;
  ohlcb_pkg::div_cnt_t   cnt_r;
  logic                  busy_r;
  ohlcb_pkg::total_ext_t rem2;
  ohlcb_pkg::total_ext_t diff;
  logic                  ge;

  always_comb begin
    hi   = num[ohlcb_pkg::SUM_BITS-1:ohlcb_pkg::PRICE_BITS];
    ovf  = ohlcb_pkg::cmp_t'(hi) >= ohlcb_pkg::cmp_t'(den);
    rem2 = {rem_r, lo_sr_r[ohlcb_pkg::PRICE_BITS-1]};
    diff = rem2 - ohlcb_pkg::total_ext_t'(den_r);
    ge   = rem2 >= ohlcb_pkg::total_ext_t'(den_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= (den != '0) && !ovf;
      cnt_r  <= ohlcb_pkg::div_cnt_t'(ohlcb_pkg::PRICE_BITS);
    end else if (busy_r) begin
      cnt_r <= cnt_r - ohlcb_pkg::div_cnt_t'(1);
      if (cnt_r == ohlcb_pkg::div_cnt_t'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_r   <= den;
      lo_sr_r <= num[ohlcb_pkg::PRICE_BITS-1:0];
      // hi < den whenever the loop runs, so it fits the remainder
      rem_r   <= ohlcb_pkg::total_t'(hi);
      q_r     <= (den != '0 && ovf) ? '1 : '0;
    end else if (busy_r) begin
      rem_r   <= ge ? diff[ohlcb_pkg::TOTAL_BITS-1:0]
                    : rem2[ohlcb_pkg::TOTAL_BITS-1:0];
      q_r     <= {q_r[ohlcb_pkg::PRICE_BITS-2:0], ge};
      lo_sr_r <= {lo_sr_r[ohlcb_pkg::PRICE_BITS-2:0], 1'b0};
    end
  end

  assign stat.busy   = busy_r;
  assign quo         = q_r;

endmodule

`default_nettype wire
